[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the urgent insert service queue.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define USQ_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);

// Check that a condition in one cycle is followed by another in the next.
`define USQ_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error(msg);

`endif

[rtl/usq_pkg.sv]
// ----------------------------------------------------------------------------
// usq_pkg
// Types and constants shared by the queue cells, the control and the top.
// ----------------------------------------------------------------------------
package usq_pkg;

    localparam int CMD_W       = 2;
    localparam int PERSON_W    = 16;
    localparam int CLASS_W     = 8;
    localparam int DUR_W       = 10;
    localparam int COUNT_OUT_W = 5;

    localparam logic [CMD_W-1:0] CMD_NORMAL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_URGENT = 2'd2;

    // Source of a cell's next job
    typedef enum logic [1:0] {
        SEL_HOLD,
        SEL_FRESH,
        SEL_LEFT,
        SEL_RIGHT
    } cell_sel_t;

    typedef struct packed {
        cell_sel_t sel;
        logic      dec;
    } cell_ctrl_t;

    typedef struct packed {
        logic take_fresh;
        logic serve;
        logic pop;
        logic drop;
    } usq_status_t;

endpackage

[rtl/usq_cell.sv]
// ----------------------------------------------------------------------------
// usq_cell
// One queue slot: picks its next job from itself, a new request or a
// neighbor, and optionally counts the job's time down by one.
// ----------------------------------------------------------------------------
module usq_cell #(
    parameter int JOB_W  = 44,
    parameter int TIME_W = 10
) (
    input  logic                aclk,
    input  logic                en,
    input  usq_pkg::cell_ctrl_t ctrl,
    input  logic [JOB_W-1:0]    fresh,
    input  logic [JOB_W-1:0]    left,
    input  logic [JOB_W-1:0]    right,
    output logic [JOB_W-1:0]    job
);
    import usq_pkg::*;

    logic [JOB_W-1:0] job_reg;
    logic [JOB_W-1:0] job_next;
    logic [JOB_W-1:0] pick;

    always_comb begin
        case (ctrl.sel)
            SEL_HOLD:  pick = job_reg;
            SEL_FRESH: pick = fresh;
            SEL_LEFT:  pick = left;
            SEL_RIGHT: pick = right;
            default:   pick = job_reg;
        endcase
        job_next = pick;
        // count down only while time is left
        if (ctrl.dec && (pick[TIME_W-1:0] != '0)) begin
            job_next[TIME_W-1:0] = pick[TIME_W-1:0] - TIME_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            job_reg <= job_next;
        end
    end

    assign job = job_reg;

endmodule

[rtl/usq_ctrl.sv]
// ----------------------------------------------------------------------------
// usq_ctrl
// Decides per tick where a request goes, whether the head is served or
// removed, and which source each cell of the chain takes.
// ----------------------------------------------------------------------------
module usq_ctrl #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TIME_BITS   = 10,
    parameter int CNT_W       = 5
) (
    input  logic [usq_pkg::CMD_W-1:0] cmd,
    input  logic [CNT_W-1:0]          count,
    input  logic [TIME_BITS-1:0]      fresh_time,
    input  logic [TIME_BITS-1:0]      head_time,
    output logic [CNT_W-1:0]          count_next,
    output usq_pkg::usq_status_t      status,
    output usq_pkg::cell_ctrl_t       cell_ctrl [QUEUE_DEPTH]
);
    import usq_pkg::*;

    logic                 req_norm;
    logic                 req_urg;
    logic                 full;
    logic                 empty;
    logic                 ins_norm;
    logic                 ins_urg;
    logic                 ins;
    logic                 occupied;
    logic [TIME_BITS-1:0] v0_time;
    logic                 pop;

    always_comb begin
        req_norm = (cmd == CMD_NORMAL);
        req_urg  = (cmd == CMD_URGENT);
        full     = (count == CNT_W'(QUEUE_DEPTH));
        empty    = (count == '0);
        ins_norm = req_norm && !full;
        ins_urg  = req_urg && !full;
        ins      = ins_norm || ins_urg;
        occupied = ins || !empty;
        // a request into an empty queue becomes the head right away
        v0_time  = (ins && empty) ? fresh_time : head_time;
        pop      = occupied && (v0_time[TIME_BITS-1:1] == '0);

        status.take_fresh = ins && empty;
        status.serve      = occupied && (v0_time != '0);
        status.pop        = pop;
        status.drop       = (req_norm || req_urg) && full;

        count_next = count + CNT_W'(ins) - CNT_W'(pop);
    end

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            cell_ctrl[i].sel = SEL_HOLD;
            cell_ctrl[i].dec = 1'b0;
            if (pop) begin
                if (ins_urg && !empty) begin
                    // new job sits behind the head, and the head leaves
                    cell_ctrl[i].sel = (i == 0) ? SEL_FRESH : SEL_HOLD;
                end else if (ins_norm && (CNT_W'(i + 1) == count)) begin
                    cell_ctrl[i].sel = SEL_FRESH;
                end else begin
                    cell_ctrl[i].sel = SEL_RIGHT;
                end
            end else begin
                cell_ctrl[i].dec = (i == 0);
                if (ins_urg && !empty) begin
                    if (i == 0) begin
                        cell_ctrl[i].sel = SEL_HOLD;
                    end else if (i == 1) begin
                        cell_ctrl[i].sel = SEL_FRESH;
                    end else begin
                        cell_ctrl[i].sel = SEL_LEFT;
                    end
                end else if (ins && (CNT_W'(i) == count)) begin
                    cell_ctrl[i].sel = SEL_FRESH;
                end
            end
        end
    end

endmodule

[rtl/urgent_insert_service_queue_core.sv]
// An accepted request's result is registered and shown in the cycle after it is accepted.
// Throughput: one request per cycle while m_ready is high; every cell of
// the chain updates in the same cycle and the single result register frees up
// whenever m_ready takes its contents.
// Reset: synchronous, active low aresetn clears the job count and the
// output valid; the job cells keep their contents and are read only once
// written.
// ----------------------------------------------------------------------------
// urgent_insert_service_queue_core
// Bounded job queue built as a chain of cells with the head in cell zero;
// normal jobs join the tail, urgent jobs slot in behind the head (or head an empty queue).
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module urgent_insert_service_queue_core #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TIME_BITS   = 10
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [usq_pkg::CMD_W-1:0]       s_cmd,
    input  logic [usq_pkg::PERSON_W-1:0]    s_person_id,
    input  logic [usq_pkg::CLASS_W-1:0]     s_class_code,
    input  logic [usq_pkg::DUR_W-1:0]       s_duration,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_serving,
    output logic                            m_served_urgent,
    output logic [usq_pkg::PERSON_W-1:0]    m_served_person,
    output logic [usq_pkg::CLASS_W-1:0]     m_served_class,
    output logic [usq_pkg::DUR_W-1:0]       m_time_left,
    output logic                            m_dropped,
    output logic [usq_pkg::COUNT_OUT_W-1:0] m_queue_count
);
    import usq_pkg::*;

    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int CLS_LO  = TIME_BITS;
    localparam int PER_LO  = TIME_BITS + CLASS_W;
    localparam int URG_BIT = TIME_BITS + CLASS_W + PERSON_W;
    localparam int JOB_W   = URG_BIT + 1;

    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic                   serving_reg;
    logic                   urgent_reg;
    logic [PERSON_W-1:0]    person_reg;
    logic [CLASS_W-1:0]     class_reg;
    logic [DUR_W-1:0]       time_reg;
    logic                   dropped_reg;
    logic [COUNT_OUT_W-1:0] qcount_reg;

    logic                   s_fire;
    logic [JOB_W-1:0]       fresh;
    logic [JOB_W-1:0]       head;
    logic [JOB_W-1:0]       shown;
    logic [JOB_W-1:0]       jobs [QUEUE_DEPTH];
    usq_status_t            status;
    cell_ctrl_t             cell_ctrl [QUEUE_DEPTH];

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    assign fresh = {(s_cmd == CMD_URGENT), s_person_id, s_class_code,
                    TIME_BITS'(s_duration)};
    assign head  = jobs[0];
    assign shown = status.take_fresh ? fresh : head;

    usq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TIME_BITS   (TIME_BITS),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .cmd        (s_cmd),
        .count      (count_reg),
        .fresh_time (fresh[TIME_BITS-1:0]),
        .head_time  (head[TIME_BITS-1:0]),
        .count_next (count_next),
        .status     (status),
        .cell_ctrl  (cell_ctrl)
    );

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic [JOB_W-1:0] left;
        logic [JOB_W-1:0] right;

        if (g == 0) begin : g_first
            assign left = fresh;
        end else begin : g_mid_l
            assign left = jobs[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign right = '0;
        end else begin : g_mid_r
            assign right = jobs[g+1];
        end

        usq_cell #(
            .JOB_W  (JOB_W),
            .TIME_W (TIME_BITS)
        ) u_cell (
            .aclk  (aclk),
            .en    (s_fire),
            .ctrl  (cell_ctrl[g]),
            .fresh (fresh),
            .left  (left),
            .right (right),
            .job   (jobs[g])
        );
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (s_fire) begin
                count_reg <= count_next;
            end
        end
    end

    // result payload, zero fields when nothing is served
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            serving_reg <= status.serve;
            urgent_reg  <= status.serve && shown[URG_BIT];
            person_reg  <= status.serve ? shown[URG_BIT-1:PER_LO] : '0;
            class_reg   <= status.serve ? shown[PER_LO-1:CLS_LO] : '0;
            time_reg    <= status.serve ? DUR_W'(shown[TIME_BITS-1:0]) : '0;
            dropped_reg <= status.drop;
            qcount_reg  <= COUNT_OUT_W'(count_next);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_serving       = serving_reg;
    assign m_served_urgent = urgent_reg;
    assign m_served_person = person_reg;
    assign m_served_class  = class_reg;
    assign m_time_left     = time_reg;
    assign m_dropped       = dropped_reg;
    assign m_queue_count   = qcount_reg;

    `USQ_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(QUEUE_DEPTH), "count over depth")
    `USQ_ASSERT_NEXT(a_count_hold, aclk, aresetn, !s_fire, $stable(count_reg), "count moved idle")
    `USQ_ASSERT_NEXT(a_drop_flag, aclk, aresetn, s_fire && status.drop, m_valid && m_dropped, "drop lost")
    `USQ_ASSERT(a_idle_zero, aclk, aresetn, (m_valid && !m_serving) |-> (m_time_left == '0), "idle time set")

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the urgent insert service queue: a clocked driver
// feeds ticks and requests in bursts, a clocked monitor stalls on its own
// pattern and checks each tick result against a job-list predictor.
// ----------------------------------------------------------------------------
module tb;
    import usq_pkg::*;

    localparam int                 DEPTH      = 16;
    localparam int                 IDLE_LIMIT = 3000;
    localparam logic [CMD_W-1:0]   CMD_TICK   = 2'd0;
    localparam logic [CMD_W-1:0]   CMD_SPARE  = 2'd3;

    typedef struct packed {
        logic                  sync_point;
        logic [CMD_W-1:0]      cmd;
        logic [PERSON_W-1:0]   person;
        logic [CLASS_W-1:0]    course;
        logic [DUR_W-1:0]      mins;
    } tick_req_t;

    typedef struct packed {
        logic                  urgent;
        logic [PERSON_W-1:0]   person;
        logic [CLASS_W-1:0]    course;
        logic [DUR_W-1:0]      mins;
    } job_t;

    typedef struct packed {
        logic                   serving;
        logic                   urgent;
        logic [PERSON_W-1:0]    person;
        logic [CLASS_W-1:0]     course;
        logic [DUR_W-1:0]       time_left;
        logic                   dropped;
        logic [COUNT_OUT_W-1:0] count;
    } tick_result_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [CMD_W-1:0]       s_cmd = '0;
    logic [PERSON_W-1:0]    s_person_id = '0;
    logic [CLASS_W-1:0]     s_class_code = '0;
    logic [DUR_W-1:0]       s_duration = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic                   m_serving;
    logic                   m_served_urgent;
    logic [PERSON_W-1:0]    m_served_person;
    logic [CLASS_W-1:0]     m_served_class;
    logic [DUR_W-1:0]       m_time_left;
    logic                   m_dropped;
    logic [COUNT_OUT_W-1:0] m_queue_count;

    tick_req_t    pending[$];
    job_t         jobs[$];
    tick_result_t tick_results[$];
    int           reqs_sent = 0;
    int           results_seen = 0;
    int           mismatches = 0;

    urgent_insert_service_queue_core #(
        .QUEUE_DEPTH (DEPTH),
        .TIME_BITS   (DUR_W)
    ) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_person_id     (s_person_id),
        .s_class_code    (s_class_code),
        .s_duration      (s_duration),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_serving       (m_serving),
        .m_served_urgent (m_served_urgent),
        .m_served_person (m_served_person),
        .m_served_class  (m_served_class),
        .m_time_left     (m_time_left),
        .m_dropped       (m_dropped),
        .m_queue_count   (m_queue_count)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Place the request (or drop it when the queue is full), serve the head once, retire a head with no time left.
    task automatic serve_tick(input tick_req_t r);
        job_t         fresh;
        tick_result_t res;
        res          = '0;
        fresh.urgent = (r.cmd == CMD_URGENT);
        fresh.person = r.person;
        fresh.course = r.course;
        fresh.mins   = r.mins;
        if (r.cmd == CMD_NORMAL || r.cmd == CMD_URGENT) begin
            if (jobs.size() >= DEPTH)
                res.dropped = 1'b1;
            else if (r.cmd == CMD_NORMAL)
                jobs.insert(jobs.size(), fresh);
            else if (jobs.size() == 0)
                jobs.insert(0, fresh);
            else
                jobs.insert(1, fresh);
        end
        if (jobs.size() > 0) begin
            if (jobs[0].mins != '0) begin
                res.serving   = 1'b1;
                res.urgent    = jobs[0].urgent;
                res.person    = jobs[0].person;
                res.course    = jobs[0].course;
                res.time_left = jobs[0].mins;
                jobs[0].mins  = jobs[0].mins - 1'b1;
            end
            if (jobs[0].mins == '0)
                jobs.delete(0);
        end
        res.count = COUNT_OUT_W'(jobs.size());
        tick_results.insert(tick_results.size(), res);
    endtask

    task automatic add_req(input logic [CMD_W-1:0] cmd, input int person, input int course,
                           input int mins);
        tick_req_t r;
        r.sync_point = 1'b0;
        r.cmd        = cmd;
        r.person     = PERSON_W'(person);
        r.course     = CLASS_W'(course);
        r.mins       = DUR_W'(mins);
        pending.insert(pending.size(), r);
    endtask

    task automatic add_sync();
        tick_req_t r;
        r            = '0;
        r.sync_point = 1'b1;
        pending.insert(pending.size(), r);
    endtask

    function automatic logic [CMD_W-1:0] pick_cmd(input int req_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < req_pct)
            return ($urandom_range(0, 1) != 0) ? CMD_URGENT : CMD_NORMAL;
        return ($urandom_range(0, 4) == 0) ? CMD_SPARE : CMD_TICK;
    endfunction

    // Sender: bursts of random length separated by random gaps.
    always @(posedge aclk) begin : driver
        int        burst_left;
        int        gap_left;
        tick_req_t on_wire;
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left  = 1;
            gap_left    = 0;
        end else begin
            if (s_valid && s_ready) begin
                serve_tick(on_wire);
                reqs_sent++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (pending[0].sync_point) begin
                    // hold until every outstanding result is back
                    s_valid <= 1'b0;
                    if (results_seen == reqs_sent)
                        pending.delete(0);
                end else begin
                    on_wire       = pending[0];
                    pending.delete(0);
                    s_valid      <= 1'b1;
                    s_cmd        <= on_wire.cmd;
                    s_person_id  <= on_wire.person;
                    s_class_code <= on_wire.course;
                    s_duration   <= on_wire.mins;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 15);
                    end
                end
            end
        end
    end

    // Receiver: stall pattern redrawn periodically from four modes, plus one long hold-off.
    always @(posedge aclk) begin : monitor
        int           rx_cycle;
        int           rx_mode;
        int           holdoff_left;
        bit           holdoff_done;
        tick_result_t got;
        tick_result_t want;
        if (!aresetn) begin
            m_ready     <= 1'b0;
            rx_cycle     = 0;
            rx_mode      = 0;
            holdoff_left = 0;
            holdoff_done = 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = '{m_serving, m_served_urgent, m_served_person, m_served_class,
                        m_time_left, m_dropped, m_queue_count};
                results_seen <= results_seen + 1;
                if (tick_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: serving=%0d person=%h count=%0d",
                                 got.serving, got.person, got.count);
                end else begin
                    want = tick_results[0];
                    tick_results.delete(0);
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch on result %0d", results_seen);
                            $display("  expected serving=%0d urgent=%0d person=%h class=%h",
                                     want.serving, want.urgent, want.person, want.course);
                            $display("           time_left=%0d dropped=%0d count=%0d",
                                     want.time_left, want.dropped, want.count);
                            $display("  actual   serving=%0d urgent=%0d person=%h class=%h",
                                     got.serving, got.urgent, got.person, got.course);
                            $display("           time_left=%0d dropped=%0d count=%0d",
                                     got.time_left, got.dropped, got.count);
                        end
                    end
                end
            end
            rx_cycle++;
            if (rx_cycle % 64 == 0)
                rx_mode = $urandom_range(0, 3);
            if (!holdoff_done && results_seen >= 250) begin
                holdoff_left = 300;
                holdoff_done = 1'b1;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                m_ready <= 1'b0;
            end else begin
                case (rx_mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 1) != 0);
                    2: m_ready <= (rx_cycle % 4 == 0);
                    default: m_ready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        int idle_cycles;
        if (!aresetn) begin
            idle_cycles = 0;
        end else if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int req_pct;
        int roll;

        // tick-only and spare command on an empty queue
        add_req(CMD_TICK, 16'hFFFF, 8'hFF, 10'h3FF);
        add_req(CMD_SPARE, 0, 0, 0);
        // zero-time job removed without service
        add_req(CMD_NORMAL, 0, 0, 0);
        // urgent onto an empty queue
        add_req(CMD_URGENT, 16'hFFFF, 8'hFF, 1);
        add_req(CMD_NORMAL, 1, 8'h11, 3);
        // later urgent goes ahead of earlier urgent, both behind the head
        add_req(CMD_URGENT, 2, 8'h22, 2);
        add_req(CMD_URGENT, 3, 8'h33, 0);
        add_req(CMD_NORMAL, 4, 8'h44, 5);
        add_req(CMD_URGENT, 5, 8'h55, 60);
        add_req(CMD_NORMAL, 6, 8'h66, 60);
        // fill to the limit, then drop both kinds
        for (int i = 0; i < 16; i++)
            add_req((i % 2 == 0) ? CMD_NORMAL : CMD_URGENT, 16'h0100 + i, i, 1 + i % 3);
        add_sync();

        for (int seg = 0; seg < 6; seg++) begin
            roll    = $urandom_range(0, 2);
            req_pct = (roll == 0) ? 15 : (roll == 1) ? 45 : 75;
            for (int i = 0; i < 50; i++)
                add_req(pick_cmd(req_pct), $urandom_range(0, 65535), $urandom_range(0, 255),
                        ($urandom_range(0, 4) != 0) ? $urandom_range(0, 3)
                                                    : $urandom_range(4, 15));
            if (seg == 2)
                add_sync();
        end

        // run the queue down, then add a maximum-time job and keep requesting
        add_sync();
        for (int i = 0; i < 100; i++)
            add_req(pick_cmd(0), $urandom_range(0, 65535), $urandom_range(0, 255),
                    $urandom_range(0, 1023));
        add_req(CMD_NORMAL, $urandom_range(0, 65535), $urandom_range(0, 255), 1023);
        for (int i = 0; i < 80; i++)
            add_req(($urandom_range(0, 3) == 0) ? pick_cmd(0) : pick_cmd(100),
                    $urandom_range(0, 65535), $urandom_range(0, 255), $urandom_range(0, 1023));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        do @(negedge aclk);
        while (pending.size() != 0 || s_valid || results_seen != reqs_sent);
        repeat (10) @(negedge aclk);

        if (mismatches == 0 && tick_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
